[rtl/core/fcsg_pkg.sv]
// fcsg_pkg: types, constants, microcode table and helpers for the filled circle span generator
`default_nettype none

package fcsg_pkg;

   // field widths
   localparam int COORD_W   = 16;
   localparam int RAD_W     = 5;
   localparam int LEN_W     = 6;
   localparam int COLOR_W   = 16;
   localparam int SQ_W      = 11;
   localparam int MAX_RADIUS_DEF = 20;

   // imax = r*707/1000 + 1, done as r*724 >> 10, exact for r up to 20
   localparam int IMAX_MUL   = 724;
   localparam int IMAX_SHIFT = 10;
   localparam int IMAX_PW    = RAD_W + IMAX_SHIFT;

   // sequencer step addresses
   typedef enum logic [2:0] {
      STEP_WAIT    = 3'd0,
      STEP_CENTRE  = 3'd1,
      STEP_OUTER_P = 3'd2,
      STEP_OUTER_M = 3'd3,
      STEP_INNER_P = 3'd4,
      STEP_INNER_M = 3'd5,
      STEP_FLUSH   = 3'd6
   } step_type;

   // span source selected by a control word
   typedef enum logic [2:0] {
      EMIT_NONE    = 3'd0,
      EMIT_CENTRE  = 3'd1,
      EMIT_OUTER_P = 3'd2,
      EMIT_OUTER_M = 3'd3,
      EMIT_INNER_P = 3'd4,
      EMIT_INNER_M = 3'd5
   } emit_type;

   // jump conditions
   typedef enum logic [1:0] {
      JMP_NEXT   = 2'd0,   // fall through
      JMP_ACCEPT = 2'd1,   // to target on request transfer, else stay
      JMP_MISS   = 2'd2,   // to target when the radius test does not hit
      JMP_LOOP   = 2'd3    // to target while i has not reached imax, or always on a flush word
   } jump_type;

   typedef struct packed {
      emit_type emit;
      logic     init_i;
      logic     dec_x;
      logic     inc_i;
      logic     flush;
      jump_type jump;
      step_type target;
   } ucode_type;

   // control program, one word per step
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      begin
         w = '{emit: EMIT_NONE, init_i: 1'b0, dec_x: 1'b0, inc_i: 1'b0,
               flush: 1'b0, jump: JMP_NEXT, target: STEP_WAIT};
         unique case (s)
            STEP_WAIT: begin
               w.jump   = JMP_ACCEPT;
               w.target = STEP_CENTRE;
            end
            STEP_CENTRE: begin
               w.emit   = EMIT_CENTRE;
               w.init_i = 1'b1;
            end
            STEP_OUTER_P: begin
               w.emit   = EMIT_OUTER_P;
               w.jump   = JMP_MISS;
               w.target = STEP_INNER_P;
            end
            STEP_OUTER_M: begin
               w.emit  = EMIT_OUTER_M;
               w.dec_x = 1'b1;
            end
            STEP_INNER_P: begin
               w.emit = EMIT_INNER_P;
            end
            STEP_INNER_M: begin
               w.emit   = EMIT_INNER_M;
               w.inc_i  = 1'b1;
               w.jump   = JMP_LOOP;
               w.target = STEP_OUTER_P;
            end
            STEP_FLUSH: begin
               w.flush  = 1'b1;
               w.jump   = JMP_LOOP;
               w.target = STEP_WAIT;
            end
            default: begin
               w.target = STEP_WAIT;
               w.jump   = JMP_LOOP;
            end
         endcase
         return w;
      end
   endfunction

   // last inner step index for a given radius
   function automatic logic [RAD_W-1:0] imax_of(input logic [RAD_W-1:0] r);
      logic [IMAX_PW-1:0] prod;
      begin
         prod = IMAX_PW'(r) * IMAX_PW'(IMAX_MUL);
         return prod[IMAX_PW-1:IMAX_SHIFT] + RAD_W'(1);
      end
   endfunction

endpackage

`default_nettype wire

[rtl/core/filled_circle_span_generator_core.sv]
// filled_circle_span_generator_core: microcoded span generator for filled circles
// a span is passed to the output register when the next span is produced or the flush step runs
// control: wait, centre, then per step i (imax = r*707/1000+1 steps) outer plus, outer minus on a hit,
//   inner plus and inner minus, then flush; one control word per cycle unless the output stalls
// the next request is taken once the flush step has passed the final span on
// reset: sequencer returns to the wait step, pending and output spans are dropped
`default_nettype none

module filled_circle_span_generator_core #(
   parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fcsg_pkg::COORD_W-1:0]  req_center_x,
   input  wire logic [fcsg_pkg::COORD_W-1:0]  req_center_y,
   input  wire logic [fcsg_pkg::RAD_W-1:0]    req_radius,
   input  wire logic [fcsg_pkg::COLOR_W-1:0]  req_fill_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [fcsg_pkg::COORD_W-1:0]       rsp_span_x,
   output logic [fcsg_pkg::COORD_W-1:0]       rsp_span_y,
   output logic [fcsg_pkg::LEN_W-1:0]         rsp_span_length,
   output logic [fcsg_pkg::COLOR_W-1:0]       rsp_span_color,
   output logic                               rsp_last_span
);

   localparam int CW = fcsg_pkg::COORD_W;
   localparam int RW = fcsg_pkg::RAD_W;
   localparam int LW = fcsg_pkg::LEN_W;
   localparam int KW = fcsg_pkg::COLOR_W;
   localparam int SW = fcsg_pkg::SQ_W;

   // sequencer and datapath registers
   fcsg_pkg::step_type  pc_ff, pc_in;
   logic [CW-1:0] cx_ff, cy_ff;
   logic [KW-1:0] color_ff;
   logic [RW-1:0] r_ff, x_ff, x_in, i_ff, i_in, imax_ff;
   logic [SW-1:0] sqmax_ff;

   // pending span, held until the next one tells whether it is the last
   logic          pend_valid_ff, pend_valid_in;
   logic [CW-1:0] pend_x_ff, pend_y_ff;
   logic [LW-1:0] pend_len_ff;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic [LW-1:0] rsp_len_ff;
   logic [KW-1:0] rsp_color_ff;
   logic          rsp_last_ff;

   fcsg_pkg::ucode_type uc;
   logic          accept, hit, outer_ok, emit_go, out_free, stall, out_load;
   logic [RW-1:0] r_sat;
   logic [SW-1:0] sum_sq;
   logic [CW-1:0] e_x, e_y;
   logic [LW-1:0] e_len;

   assign uc        = fcsg_pkg::ucode_rom(pc_ff);
   assign req_ready = (pc_ff == fcsg_pkg::STEP_WAIT);
   assign accept    = req_valid && req_ready;

   // radius saturation
   assign r_sat = (req_radius > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : req_radius;

   // radius test i*i + x*x > r*r + r/2
   assign sum_sq   = SW'(i_ff) * SW'(i_ff) + SW'(x_ff) * SW'(x_ff);
   assign hit      = sum_sq > sqmax_ff;
   assign outer_ok = hit && (x_ff > imax_ff);

   // span selection
   always_comb begin
      e_x   = cx_ff - CW'(x_ff);
      e_y   = cy_ff;
      e_len = '0;
      unique case (uc.emit)
         fcsg_pkg::EMIT_NONE: begin
            e_len = '0;
         end
         fcsg_pkg::EMIT_CENTRE: begin
            e_x   = cx_ff - CW'(r_ff);
            e_y   = cy_ff;
            e_len = {r_ff, 1'b0};
         end
         fcsg_pkg::EMIT_OUTER_P: begin
            e_x   = cx_ff - CW'(i_ff) + CW'(1);
            e_y   = cy_ff + CW'(x_ff);
            e_len = outer_ok ? {i_ff - RW'(1), 1'b0} : '0;
         end
         fcsg_pkg::EMIT_OUTER_M: begin
            e_x   = cx_ff - CW'(i_ff) + CW'(1);
            e_y   = cy_ff - CW'(x_ff);
            e_len = outer_ok ? {i_ff - RW'(1), 1'b0} : '0;
         end
         fcsg_pkg::EMIT_INNER_P: begin
            e_x   = cx_ff - CW'(x_ff);
            e_y   = cy_ff + CW'(i_ff);
            e_len = {x_ff, 1'b0};
         end
         fcsg_pkg::EMIT_INNER_M: begin
            e_x   = cx_ff - CW'(x_ff);
            e_y   = cy_ff - CW'(i_ff);
            e_len = {x_ff, 1'b0};
         end
         default: begin
            e_len = '0;
         end
      endcase
   end

   // handshake between pending span and output register
   assign emit_go  = (uc.emit != fcsg_pkg::EMIT_NONE) && (e_len != '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign stall    = (emit_go || uc.flush) && pend_valid_ff && !out_free;
   assign out_load = (emit_go || uc.flush) && pend_valid_ff && out_free;

   // next step
   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         unique case (uc.jump)
            fcsg_pkg::JMP_NEXT:   pc_in = fcsg_pkg::step_type'(pc_ff + 3'd1);
            fcsg_pkg::JMP_ACCEPT: pc_in = accept ? uc.target : pc_ff;
            fcsg_pkg::JMP_MISS:   pc_in = hit ? fcsg_pkg::step_type'(pc_ff + 3'd1) : uc.target;
            fcsg_pkg::JMP_LOOP:   pc_in = (i_ff != imax_ff || uc.flush) ? uc.target
                                          : fcsg_pkg::step_type'(pc_ff + 3'd1);
            default:              pc_in = fcsg_pkg::STEP_WAIT;
         endcase
      end
   end

   // datapath controls
   always_comb begin
      x_in          = x_ff;
      i_in          = i_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (accept) begin
         x_in = r_sat;
      end else if (!stall) begin
         if (uc.dec_x && x_ff != '0) begin
            x_in = x_ff - RW'(1);
         end
         if (uc.init_i) begin
            i_in = RW'(1);
         end else if (uc.inc_i) begin
            i_in = i_ff + RW'(1);
         end
         if (emit_go) begin
            pend_valid_in = 1'b1;
         end else if (uc.flush) begin
            pend_valid_in = 1'b0;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= fcsg_pkg::STEP_WAIT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      i_ff <= i_in;
      if (accept) begin
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         color_ff <= req_fill_color;
         r_ff     <= r_sat;
         imax_ff  <= fcsg_pkg::imax_of(r_sat);
         sqmax_ff <= SW'(r_sat) * SW'(r_sat) + SW'(r_sat >> 1);
      end
      if (emit_go && !stall) begin
         pend_x_ff   <= e_x;
         pend_y_ff   <= e_y;
         pend_len_ff <= e_len;
      end
      if (out_load) begin
         rsp_x_ff     <= pend_x_ff;
         rsp_y_ff     <= pend_y_ff;
         rsp_len_ff   <= pend_len_ff;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= uc.flush;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_span_x      = rsp_x_ff;
   assign rsp_span_y      = rsp_y_ff;
   assign rsp_span_length = rsp_len_ff;
   assign rsp_span_color  = rsp_color_ff;
   assign rsp_last_span   = rsp_last_ff;

   // a new circle starts with no span left pending
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("pending span left over at request transfer");

   // the flush step drains the pending span when it is not stalled
   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == fcsg_pkg::STEP_FLUSH && !stall) |=> !pend_valid_ff)
      else $error("flush step did not drain pending span");

   // the sequencer never moves while stalled
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(pc_ff) && $stable(x_ff) && $stable(i_ff))
      else $error("sequencer advanced during stall");

endmodule

`default_nettype wire

[test/tb_filled_circle_span_generator_core.sv]
// tb_filled_circle_span_generator_core: self-checking bench for the filled circle span generator
`timescale 1ns / 100ps

module tb_filled_circle_span_generator_core;

   localparam int MAX_RAD     = fcsg_pkg::MAX_RADIUS_DEF;
   localparam int RANDOM_REQS = 131;
   localparam int TAIL_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [fcsg_pkg::COORD_W-1:0] cx;
      logic [fcsg_pkg::COORD_W-1:0] cy;
      logic [fcsg_pkg::RAD_W-1:0]   radius;
      logic [fcsg_pkg::COLOR_W-1:0] color;
      logic                         drain;   // hold off until all spans are back
   } circle_req;

   typedef struct packed {
      logic [fcsg_pkg::COORD_W-1:0] x;
      logic [fcsg_pkg::COORD_W-1:0] y;
      logic [fcsg_pkg::LEN_W-1:0]   len;
      logic [fcsg_pkg::COLOR_W-1:0] color;
      logic                         last;
   } span_rec;

   typedef enum logic [1:0] {
      STALL_NONE  = 2'd0,
      STALL_SHORT = 2'd1,
      STALL_LONG  = 2'd2
   } stall_style;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [fcsg_pkg::COORD_W-1:0] req_center_x   = '0;
   logic [fcsg_pkg::COORD_W-1:0] req_center_y   = '0;
   logic [fcsg_pkg::RAD_W-1:0]   req_radius     = '0;
   logic [fcsg_pkg::COLOR_W-1:0] req_fill_color = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic [fcsg_pkg::COORD_W-1:0] rsp_span_x;
   logic [fcsg_pkg::COORD_W-1:0] rsp_span_y;
   logic [fcsg_pkg::LEN_W-1:0]   rsp_span_length;
   logic [fcsg_pkg::COLOR_W-1:0] rsp_span_color;
   logic                         rsp_last_span;

   circle_req pending_circles[$];
   span_rec   expected_spans[$];
   span_rec   circle_spans[$];
   int        fail_count = 0;
   int        cycle_count = 0;

   filled_circle_span_generator_core #(
      .MAX_RADIUS(MAX_RAD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius(req_radius),
      .req_fill_color(req_fill_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_span_x(rsp_span_x),
      .rsp_span_y(rsp_span_y),
      .rsp_span_length(rsp_span_length),
      .rsp_span_color(rsp_span_color),
      .rsp_last_span(rsp_last_span)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // zero-length spans are dropped, coordinates wrap at 16 bits and lengths at 6 bits
   function automatic void push_span(input logic [31:0] sx, input logic [31:0] sy,
                                     input logic [31:0] len, input logic [15:0] color);
      span_rec s;
      if (len == 0) return;
      s.x     = sx[15:0];
      s.y     = sy[15:0];
      s.len   = len[5:0];
      s.color = color;
      s.last  = 1'b0;
      circle_spans.push_back(s);
   endfunction

   // centre row, then outer and inner row pairs per step
   function automatic void predict_circle(input circle_req c);
      logic [31:0] r, imax, sqmax, x, i;
      circle_spans.delete();
      r = 32'(c.radius);
      if (r > MAX_RAD) r = MAX_RAD;
      if (r == 0) return;
      imax  = r * 707 / 1000 + 1;
      sqmax = r * r + r / 2;
      x     = r;
      push_span(c.cx - r, c.cy, 2 * r, c.color);
      for (i = 1; i <= imax; i++) begin
         if (i * i + x * x > sqmax) begin
            if (x > imax) begin
               push_span(c.cx - i + 1, c.cy + x, 2 * (i - 1), c.color);
               push_span(c.cx - i + 1, c.cy - x, 2 * (i - 1), c.color);
            end
            if (x > 0) x = x - 1;
         end
         push_span(c.cx - x, c.cy + i, 2 * x, c.color);
         push_span(c.cx - x, c.cy - i, 2 * x, c.color);
      end
      circle_spans[circle_spans.size() - 1].last = 1'b1;
      foreach (circle_spans[k]) expected_spans.push_back(circle_spans[k]);
   endfunction

   function automatic circle_req make_circle(input logic [15:0] cx, input logic [15:0] cy,
                                             input logic [4:0] radius,
                                             input logic [15:0] color, input logic drain);
      circle_req c;
      c.cx     = cx;
      c.cy     = cy;
      c.radius = radius;
      c.color  = color;
      c.drain  = drain;
      return c;
   endfunction

   // coordinates near both edges a quarter of the time
   function automatic logic [15:0] random_coord();
      if ($urandom_range(0, 3) != 0) return 16'($urandom);
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 40));
      return 16'(65535 - $urandom_range(0, 40));
   endfunction

   // mostly legal radii, sometimes zero or above the maximum
   function automatic logic [4:0] random_radius();
      if ($urandom_range(0, 7) != 0) return 5'($urandom_range(1, MAX_RAD));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // request driver: bursts with random gaps, optional drain before an item
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : req_driver
      circle_req cur;
      logic      holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid && !req_ready;
         if (!holding) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_circles.size() != 0 &&
                         !(pending_circles[0].drain &&
                           (req_valid || expected_spans.size() != 0))) begin
               cur = pending_circles.pop_front();
               req_valid      <= 1'b1;
               req_center_x   <= cur.cx;
               req_center_y   <= cur.cy;
               req_radius     <= cur.radius;
               req_fill_color <= cur.color;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // span monitor: predict on request transfer, check on span transfer
   stall_style stall_mode  = STALL_NONE;
   int         stall_left  = 0;
   int         mode_timer  = 0;

   always @(posedge clock) begin : span_monitor
      span_rec exp_span;
      if (!reset) begin
         if (req_valid && req_ready)
            predict_circle(make_circle(req_center_x, req_center_y, req_radius,
                                       req_fill_color, 1'b0));
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               $display("%0t: unexpected span x=%h y=%h len=%0d color=%h last=%b", $time,
                        rsp_span_x, rsp_span_y, rsp_span_length, rsp_span_color,
                        rsp_last_span);
               fail_count++;
            end else begin
               exp_span = expected_spans.pop_front();
               check_field("span_x", exp_span.x, rsp_span_x);
               check_field("span_y", exp_span.y, rsp_span_y);
               check_field("span_length", 16'(exp_span.len), 16'(rsp_span_length));
               check_field("span_color", exp_span.color, rsp_span_color);
               check_field("last_span", 16'(exp_span.last), 16'(rsp_last_span));
            end
         end
      end

      // receiver stall pattern, style changes every so often
      if (mode_timer == 0) begin
         mode_timer <= $urandom_range(50, 300);
         stall_mode <= stall_style'($urandom_range(0, 2));
      end else begin
         mode_timer <= mode_timer - 1;
      end
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         case (stall_mode)
            STALL_SHORT: if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 2);
            STALL_LONG:  if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 12);
            default: ;
         endcase
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("filled_circle_span_generator_core test failed");
         $finish;
      end
   end

   initial begin : stimulus
      circle_req c;
      int        n;

      // directed: size sweep, zero and saturated radius, wrap at both edges
      pending_circles.push_back(make_circle(16'd100, 16'd100, 5'd1, 16'h0000, 1'b0));
      pending_circles.push_back(make_circle(16'd100, 16'd100, 5'd2, 16'hffff, 1'b0));
      pending_circles.push_back(make_circle(16'd1000, 16'd2000, 5'd3, 16'h1234, 1'b0));
      pending_circles.push_back(make_circle(16'd500, 16'd600, 5'd4, 16'hf800, 1'b0));
      pending_circles.push_back(make_circle(16'd500, 16'd600, 5'd7, 16'h07e0, 1'b0));
      pending_circles.push_back(make_circle(16'd320, 16'd240, 5'd10, 16'h001f, 1'b0));
      pending_circles.push_back(make_circle(16'd320, 16'd240, 5'd14, 16'h5555, 1'b0));
      pending_circles.push_back(make_circle(16'd320, 16'd240, 5'd16, 16'haaaa, 1'b0));
      pending_circles.push_back(make_circle(16'd320, 16'd240, 5'd17, 16'h8001, 1'b0));
      pending_circles.push_back(make_circle(16'd320, 16'd240, 5'd20, 16'h7ffe, 1'b0));
      pending_circles.push_back(make_circle(16'hffff, 16'hffff, 5'd0, 16'habcd, 1'b0));
      pending_circles.push_back(make_circle(16'd50, 16'd60, 5'd21, 16'h0f0f, 1'b0));
      pending_circles.push_back(make_circle(16'd50, 16'd60, 5'd31, 16'hf0f0, 1'b0));
      pending_circles.push_back(make_circle(16'h0000, 16'h0000, 5'd20, 16'h5a5a, 1'b1));
      pending_circles.push_back(make_circle(16'hffff, 16'hffff, 5'd20, 16'ha5a5, 1'b0));
      pending_circles.push_back(make_circle(16'hffff, 16'h0000, 5'd5, 16'h3c3c, 1'b0));
      pending_circles.push_back(make_circle(16'h0000, 16'hffff, 5'd8, 16'hc3c3, 1'b0));
      pending_circles.push_back(make_circle(16'h8000, 16'h7fff, 5'd19, 16'hffff, 1'b0));
      pending_circles.push_back(make_circle(16'h0003, 16'hfffd, 5'd0, 16'h0000, 1'b0));

      // random circles, with a drain point every few dozen
      for (n = 0; n < RANDOM_REQS; n++) begin
         c = make_circle(random_coord(), random_coord(), random_radius(),
                         16'($urandom), (n % 40) == 39);
         pending_circles.push_back(c);
      end

      // sample between edges so queue and handshake updates have settled
      @(negedge reset);
      while (pending_circles.size() != 0 || req_valid || expected_spans.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("filled_circle_span_generator_core test passed");
      else
         $display("filled_circle_span_generator_core test failed");
      $finish;
   end

   // initial reset, then release
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
